>>> rtl/omrs_pkg.sv
// Shared types and codes of the ordered map rank/select unit.
// Used by omrs_ctrl, omrs_datapath and ordered_map_rank_select_unit.
package omrs_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_SELECT = 2'd3
  } omrs_cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_RANK  = 2'd3
  } omrs_status_e;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_MV_DN,
    RD_MV_UP,
    RD_RANK
  } omrs_rd_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_MV_RD,
    S_MV_WR,
    S_PUT,
    S_SEL_RD,
    S_DONE_OK,
    S_DONE_VAL,
    S_DONE_NF,
    S_DONE_FULL,
    S_DONE_RANK
  } omrs_state_e;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValW   = 64;
  localparam int unsigned RankW  = 8;
  localparam int unsigned HeldW  = 9;
  localparam logic [KeyW-1:0] SignFlip = 32'h8000_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         load_req;
    logic         clr_idx;
    logic         inc_idx;
    logic         mem_rd;
    omrs_rd_sel_e rd_sel;
    logic         mv_from_fill;
    logic         mv_from_idx;
    logic         mv_dec;
    logic         mv_inc;
    logic         wr_shift;
    logic         wr_put;
    logic         fill_inc;
    logic         fill_dec;
    logic         out_load;
    omrs_status_e out_status;
    logic         out_take_rd;
  } omrs_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    omrs_cmd_e cmd;
    logic      idx_end;
    logic      go_on;
    logic      key_eq;
    logic      full;
    logic      rank_bad;
    logic      mv_at_idx;
    logic      mv_last;
    logic      out_free;
  } omrs_stat_t;

endpackage

>>> rtl/omrs_ctrl.sv
// Sequencer of the ordered map rank/select unit: search, shift, write, report.
// Depends on omrs_pkg; drives omrs_datapath through omrs_ctrl_t.
module omrs_ctrl
  import omrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  omrs_stat_t stat_i,
  output omrs_ctrl_t ctrl_o
);

  omrs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (stat_i.cmd)
          CMD_INSERT: state_d = stat_i.full ? S_DONE_FULL : S_SRCH_RD;
          CMD_SELECT: state_d = stat_i.rank_bad ? S_DONE_RANK : S_SEL_RD;
          default:    state_d = S_SRCH_RD;
        endcase
      end
      S_SRCH_RD: begin
        if (!stat_i.idx_end) state_d = S_SRCH_CMP;
        else if (stat_i.cmd == CMD_INSERT) state_d = S_MV_RD;
        else state_d = S_DONE_NF;
      end
      S_SRCH_CMP: begin
        if (stat_i.go_on) state_d = S_SRCH_RD;
        else if (stat_i.cmd == CMD_INSERT) state_d = S_MV_RD;
        else if (!stat_i.key_eq) state_d = S_DONE_NF;
        else if (stat_i.cmd == CMD_LOOKUP) state_d = S_DONE_VAL;
        else state_d = S_MV_RD;
      end
      S_MV_RD: begin
        if (stat_i.cmd == CMD_INSERT) state_d = stat_i.mv_at_idx ? S_PUT : S_MV_WR;
        else state_d = stat_i.mv_last ? S_DONE_OK : S_MV_WR;
      end
      S_MV_WR:  state_d = S_MV_RD;
      S_PUT:    state_d = S_DONE_OK;
      S_SEL_RD: state_d = S_DONE_VAL;
      S_DONE_OK, S_DONE_VAL, S_DONE_NF, S_DONE_FULL, S_DONE_RANK: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.rd_sel = RD_IDX;
    ctrl_o.out_status = ST_OK;
    req_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        ctrl_o.load_req = req_valid_i;
        ctrl_o.clr_idx  = req_valid_i;
      end
      S_SRCH_RD: begin
        if (!stat_i.idx_end) ctrl_o.mem_rd = 1'b1;
        else if (stat_i.cmd == CMD_INSERT) ctrl_o.mv_from_fill = 1'b1;
      end
      S_SRCH_CMP: begin
        if (stat_i.go_on) ctrl_o.inc_idx = 1'b1;
        else if (stat_i.cmd == CMD_INSERT) ctrl_o.mv_from_fill = 1'b1;
        else if (stat_i.key_eq && stat_i.cmd == CMD_DELETE) ctrl_o.mv_from_idx = 1'b1;
      end
      S_MV_RD: begin
        if (stat_i.cmd == CMD_INSERT) begin
          if (!stat_i.mv_at_idx) begin
            ctrl_o.mem_rd = 1'b1;
            ctrl_o.rd_sel = RD_MV_DN;
          end
        end else if (stat_i.mv_last) begin
          ctrl_o.fill_dec = 1'b1;
        end else begin
          ctrl_o.mem_rd = 1'b1;
          ctrl_o.rd_sel = RD_MV_UP;
        end
      end
      S_MV_WR: begin
        ctrl_o.wr_shift = 1'b1;
        if (stat_i.cmd == CMD_INSERT) ctrl_o.mv_dec = 1'b1;
        else ctrl_o.mv_inc = 1'b1;
      end
      S_PUT: begin
        ctrl_o.wr_put   = 1'b1;
        ctrl_o.fill_inc = 1'b1;
      end
      S_SEL_RD: begin
        ctrl_o.mem_rd = 1'b1;
        ctrl_o.rd_sel = RD_RANK;
      end
      S_DONE_OK: ctrl_o.out_load = stat_i.out_free;
      S_DONE_VAL: begin
        ctrl_o.out_load    = stat_i.out_free;
        ctrl_o.out_take_rd = 1'b1;
      end
      S_DONE_NF: begin
        ctrl_o.out_load   = stat_i.out_free;
        ctrl_o.out_status = ST_NOT_FOUND;
      end
      S_DONE_FULL: begin
        ctrl_o.out_load   = stat_i.out_free;
        ctrl_o.out_status = ST_FULL;
      end
      S_DONE_RANK: begin
        ctrl_o.out_load   = stat_i.out_free;
        ctrl_o.out_status = ST_BAD_RANK;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/omrs_datapath.sv
// Datapath of the ordered map rank/select unit: request registers, counters,
// entry memory and result register. Depends on omrs_pkg.
module omrs_datapath
  import omrs_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  omrs_ctrl_t         ctrl_i,
  output omrs_stat_t         stat_o,
  input  logic [1:0]         command_i,
  input  logic [KeyW-1:0]    key_i,
  input  logic [ValW-1:0]    value_in_i,
  input  logic [RankW-1:0]   rank_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ValW-1:0]    value_out_o,
  output logic [1:0]         status_o,
  output logic [HeldW-1:0]   entries_held_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned IW = AW + 1;
  localparam int unsigned CW = (IW > RankW) ? IW : RankW;
  localparam int unsigned EW = KeyW + ValW;

  omrs_cmd_e         cmd_q;
  logic [KeyW-1:0]   key_q;
  logic [ValW-1:0]   val_q;
  logic [RankW-1:0]  rank_q;
  logic [IW-1:0]     idx_q, mv_q, fill_q;
  logic [EW-1:0]     mem [CAPACITY];
  logic [EW-1:0]     rd_q;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [EW-1:0]     wr_data;
  logic [IW-1:0]     mv_dn, mv_up;
  logic [KeyW-1:0]   rd_key;
  logic              out_valid_q;
  logic [ValW-1:0]   out_val_q;
  logic [1:0]        out_st_q;
  logic [HeldW-1:0]  out_held_q;

  assign rd_key = rd_q[EW-1 -: KeyW];
  assign mv_dn  = mv_q - IW'(1);
  assign mv_up  = mv_q + IW'(1);

  // Request and index registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_req) begin
      cmd_q  <= omrs_cmd_e'(command_i);
      key_q  <= key_i ^ SignFlip;
      val_q  <= value_in_i;
      rank_q <= rank_i;
    end
    if (ctrl_i.clr_idx) idx_q <= '0;
    else if (ctrl_i.inc_idx) idx_q <= idx_q + IW'(1);
    if (ctrl_i.mv_from_fill) mv_q <= fill_q;
    else if (ctrl_i.mv_from_idx) mv_q <= idx_q;
    else if (ctrl_i.mv_dec) mv_q <= mv_dn;
    else if (ctrl_i.mv_inc) mv_q <= mv_up;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (ctrl_i.fill_inc) begin
      fill_q <= fill_q + IW'(1);
    end else if (ctrl_i.fill_dec) begin
      fill_q <= fill_q - IW'(1);
    end
  end

  always_comb begin
    unique case (ctrl_i.rd_sel)
      RD_IDX:   rd_addr = idx_q[AW-1:0];
      RD_MV_DN: rd_addr = mv_dn[AW-1:0];
      RD_MV_UP: rd_addr = mv_up[AW-1:0];
      RD_RANK:  rd_addr = AW'(rank_q);
      default:  rd_addr = idx_q[AW-1:0];
    endcase
  end

  assign wr_addr = ctrl_i.wr_put ? idx_q[AW-1:0] : mv_q[AW-1:0];
  assign wr_data = ctrl_i.wr_put ? {key_q, val_q} : rd_q;

  // Entry memory: key (sign flipped) above value.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_put || ctrl_i.wr_shift) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_rd) rd_q <= mem[rd_addr];
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Capture the entry count with the result so it holds while the next
  // request already changes the table.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_val_q  <= ctrl_i.out_take_rd ? rd_q[ValW-1:0] : '0;
      out_st_q   <= ctrl_i.out_status;
      out_held_q <= HeldW'(fill_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign value_out_o    = out_val_q;
  assign status_o       = out_st_q;
  assign entries_held_o = out_held_q;

  always_comb begin
    stat_o.cmd       = cmd_q;
    stat_o.idx_end   = (idx_q >= fill_q);
    stat_o.go_on     = (cmd_q == CMD_INSERT) ? (rd_key <= key_q) : (rd_key < key_q);
    stat_o.key_eq    = (rd_key == key_q);
    stat_o.full      = (fill_q >= IW'(CAPACITY));
    stat_o.rank_bad  = (CW'(rank_q) >= CW'(fill_q));
    stat_o.mv_at_idx = (mv_q == idx_q);
    stat_o.mv_last   = (mv_up >= fill_q);
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= IW'(CAPACITY)) else $error("fill count above capacity");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.wr_put && ctrl_i.wr_shift)) else $error("two writes in one cycle");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.fill_inc |=> fill_q == $past(fill_q) + IW'(1))
    else $error("fill count did not advance by one");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");

endmodule

>>> rtl/ordered_map_rank_select_unit.sv
// Top level of the ordered map rank/select unit.
// Depends on omrs_pkg, omrs_ctrl and omrs_datapath.
//
// Sorted key/value table of up to CAPACITY entries in one single-port-write
// memory, ascending by signed key, equal keys in arrival order. One request
// at a time; each gives exactly one result. The search is linear: it reads
// and compares one entry at a time over the single memory read port, and
// every shift reads and then writes one entry at a time. A finished
// result waits in the output register while the next request is accepted.
module ordered_map_rank_select_unit
  import omrs_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // key[31:0], value_in[95:32], rank[103:96]
  input  logic [1:0]   s_axis_tuser,  // command[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata,  // value_out[63:0], entries_held[72:64], zero
  output logic [1:0]   m_axis_tuser   // status[1:0]
);

  omrs_ctrl_t          ctrl;
  omrs_stat_t          stat;
  logic [ValW-1:0]     value_out;
  logic [HeldW-1:0]    entries_held;

  omrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  omrs_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .command_i      (s_axis_tuser),
    .key_i          (s_axis_tdata[31:0]),
    .value_in_i     (s_axis_tdata[95:32]),
    .rank_i         (s_axis_tdata[103:96]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .value_out_o    (value_out),
    .status_o       (m_axis_tuser),
    .entries_held_o (entries_held)
  );

  assign m_axis_tdata = {7'd0, entries_held, value_out};

endmodule

>>> tb/tb_top.sv
// Testbench for ordered_map_rank_select_unit: random and directed requests on the
// input stream, results checked against a sorted-table predictor.
// Depends on omrs_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_top;
  import omrs_pkg::*;

  localparam int unsigned Cap = 256;
  localparam int unsigned IdleLimit = 20000;

  typedef struct {
    omrs_cmd_e   cmd;
    logic [31:0] key;
    logic [63:0] val;
    logic [7:0]  rank;
  } req_t;

  typedef struct {
    logic [63:0]  val;
    omrs_status_e status;
    logic [8:0]   held;
  } rsp_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;  // key, value_in, rank
  logic [1:0]   s_axis_tuser = '0;  // command
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [79:0]  m_axis_tdata;  // value_out, entries_held, zero
  logic [1:0]   m_axis_tuser;  // status

  ordered_map_rank_select_unit #(.CAPACITY(Cap)) u_top (.*);

  initial forever #5 clk_i = ~clk_i;

  // Predictor state: keys held with sign flipped for unsigned order.
  logic [31:0] tbl_key[Cap];
  logic [63:0] tbl_val[Cap];
  int unsigned tbl_n = 0;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  bit   quiet = 1'b0;     // no idling at the end
  bit   hold_src = 1'b0;  // sender paused until drained
  int   src_gap = 0;
  int   sink_gap = 0;
  int   idle_cycles = 0;
  logic [31:0] used_keys[$];
  logic accepted_q = 1'b0;

  function automatic rsp_t predict_table(req_t r);
    rsp_t o;
    logic [31:0] k;
    int unsigned p;
    o.val = '0;
    o.status = ST_OK;
    k = r.key ^ SignFlip;
    p = 0;
    case (r.cmd)
      CMD_INSERT: begin
        if (tbl_n >= Cap) o.status = ST_FULL;
        else begin
          while (p < tbl_n && tbl_key[p] <= k) p++;
          for (int i = tbl_n; i > p; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_val[i] = tbl_val[i-1];
          end
          tbl_key[p] = k;
          tbl_val[p] = r.val;
          tbl_n++;
        end
      end
      CMD_LOOKUP, CMD_DELETE: begin
        while (p < tbl_n && tbl_key[p] < k) p++;
        if (p >= tbl_n || tbl_key[p] != k) o.status = ST_NOT_FOUND;
        else if (r.cmd == CMD_LOOKUP) o.val = tbl_val[p];
        else begin
          for (int i = p; i + 1 < tbl_n; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_val[i] = tbl_val[i+1];
          end
          tbl_n--;
        end
      end
      default: begin
        if (r.rank >= tbl_n) o.status = ST_BAD_RANK;
        else o.val = tbl_val[r.rank];
      end
    endcase
    o.held = tbl_n[8:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // Pick a key: mostly one seen before so lookups and deletes hit.
  function automatic logic [31:0] pick_key();
    if (used_keys.size() > 0 && $urandom_range(0, 3) != 0)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 15) - 8;
      default: return $urandom();
    endcase
  endfunction

  task automatic push_req(omrs_cmd_e c, logic [31:0] k, logic [63:0] v, logic [7:0] rk);
    req_t r;
    r.cmd = c; r.key = k; r.val = v; r.rank = rk;
    pending_reqs.push_back(r);
    if (c == CMD_INSERT) used_keys.push_back(k);
  endtask

  // Driver: present the next request at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        // accepted at the last rising edge; the monitor predicted it
      end
      if (!s_axis_tvalid || accepted_q) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     !(hold_src && expected_rsps.size() > 0)) begin
          req_t r;
          r = pending_reqs.pop_front();
          s_axis_tdata <= {r.rank, r.val, r.key};
          s_axis_tuser <= r.cmd;
          s_axis_tvalid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 3);
        end else s_axis_tvalid <= 1'b0;
      end
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) sink_gap <= $urandom_range(1, 3);
      end
    end
  end

  // Monitor: predict accepted requests, check accepted results.
  always @(posedge clk_i) begin
    req_t r;
    rsp_t e;
    bit   act;
    accepted_q <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      act = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        r.cmd = omrs_cmd_e'(s_axis_tuser);
        r.key = s_axis_tdata[31:0];
        r.val = s_axis_tdata[95:32];
        r.rank = s_axis_tdata[103:96];
        expected_rsps.push_back(predict_table(r));
        act = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        act = 1'b1;
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[63:0], 64'd0);
        end else begin
          e = expected_rsps.pop_front();
          if (m_axis_tdata[63:0] !== e.val) report_mismatch("value", m_axis_tdata[63:0], e.val);
          if (m_axis_tuser !== e.status)
            report_mismatch("status", 64'(m_axis_tuser), 64'(e.status));
          if (m_axis_tdata[72:64] !== e.held)
            report_mismatch("held", 64'(m_axis_tdata[72:64]), 64'(e.held));
          if (m_axis_tdata[79:73] !== '0)
            report_mismatch("pad", 64'(m_axis_tdata[79:73]), 64'd0);
        end
      end
      idle_cycles <= act ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned mode;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: empty table cases, key extremes, equal keys, all commands.
    push_req(CMD_LOOKUP, 32'h0, '1, 8'hff);
    push_req(CMD_DELETE, 32'h8000_0000, '0, 8'h0);
    push_req(CMD_SELECT, '1, '1, 8'h0);
    push_req(CMD_INSERT, 32'h7fff_ffff, 64'hffff_ffff_ffff_ffff, 8'hff);
    push_req(CMD_INSERT, 32'h8000_0000, 64'h0, 8'h0);
    push_req(CMD_INSERT, 32'h0, 64'h1111, 8'h0);
    push_req(CMD_INSERT, 32'h0, 64'h2222, 8'h0);
    push_req(CMD_INSERT, 32'hffff_ffff, 64'h5555_aaaa_5555_aaaa, 8'h0);
    for (int i = 0; i < 6; i++) push_req(CMD_SELECT, '1, '0, 8'(i));
    push_req(CMD_LOOKUP, 32'h0, '0, 8'h0);
    push_req(CMD_DELETE, 32'h0, '0, 8'h0);
    push_req(CMD_LOOKUP, 32'h0, '0, 8'h0);
    push_req(CMD_LOOKUP, 32'h7fff_ffff, '0, 8'h0);
    push_req(CMD_LOOKUP, 32'h8000_0000, '0, 8'h0);
    push_req(CMD_LOOKUP, 32'h1, '0, 8'h0);
    push_req(CMD_DELETE, 32'h7fff_ffff, '0, 8'h0);
    push_req(CMD_SELECT, '0, '0, 8'hff);
    wait (pending_reqs.size() == 0 && !s_axis_tvalid);

    // Pause the sender until every result is back.
    hold_src = 1'b1;
    wait (expected_rsps.size() == 0);
    hold_src = 1'b0;

    // Fill the table to capacity, then probe full behavior.
    for (int i = 0; i < Cap + 2; i++)
      push_req(CMD_INSERT, pick_key(), rnd64(), 8'($urandom()));
    push_req(CMD_SELECT, '0, '0, 8'hff);
    push_req(CMD_LOOKUP, 32'h7fff_ffff, '0, 8'h0);
    wait (pending_reqs.size() < 4);

    // Random mix with a bias that walks the fill level up and down.
    for (int i = 0; i < 470; i++) begin
      if (i == 400) begin
        wait (pending_reqs.size() == 0);
        quiet = 1'b1;
      end
      mode = $urandom_range(0, 9);
      if (i < 250) mode = (mode < 6) ? 2 : mode;
      if (mode < 3) push_req(CMD_DELETE, pick_key(), rnd64(), 8'($urandom()));
      else if (mode < 5) push_req(CMD_INSERT, pick_key(), rnd64(), 8'($urandom()));
      else if (mode < 7) push_req(CMD_LOOKUP, pick_key(), rnd64(), 8'($urandom()));
      else push_req(CMD_SELECT, $urandom(), rnd64(), 8'($urandom()));
      if (pending_reqs.size() > 8) wait (pending_reqs.size() <= 8);
    end

    wait (pending_reqs.size() == 0 && !s_axis_tvalid);
    wait (expected_rsps.size() == 0);
    repeat (1200) @(posedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
